// File: hw/rtl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg: shared types for the hash ring successor lookup
// Opcodes, status codes, controller states and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int OpW     = 2;
  localparam int HashW   = 32;
  localparam int NodeW   = 8;
  localparam int StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_LKP_RD,
    S_LKP_OUT,
    S_INS_RD,
    S_INS_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR
  } state_e;

  typedef struct packed {
    logic    load;        // latch request, open search window [0, count)
    logic    clear;       // empty the ring
    logic    srch_rd;     // read the midpoint of the window
    logic    srch_upd;    // narrow the window from the point just read
    logic    lkp_rd;      // read the successor entry, wrapping to entry zero
    logic    pos_rd;      // read the entry at the insert position
    logic    shift_init;  // start moving the tail up from the top
    logic    shift_rd;    // read the entry below the shift pointer
    logic    shift_wr;    // write it one slot up and step down
    logic    wr_pos;      // write point and owner at the insert position
    logic    cnt_inc;     // one more point on the ring
    logic    emit;        // present a result
    status_e emit_status;
    logic    emit_node;   // result carries the owner just read
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic lo_lt_hi;
    logic pos_in_ring;
    logic hit;
    logic shift_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/hrs_dpath.sv
// ----------------------------------------------------------------------------
// hrs_dpath: ring table and search datapath
// Holds the sorted point/owner memory, the point count, the binary search
// window, the tail shift pointer and the result registers.
// ----------------------------------------------------------------------------
module hrs_dpath #(
  parameter int MAX_POINTS = 4096,
  parameter int NODE_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [hrs_pkg::HashW-1:0]    hash_value_i,
  input  logic [hrs_pkg::NodeW-1:0]    node_in_i,
  input  hrs_pkg::dp_cmd_t             cmd_i,
  output hrs_pkg::dp_stat_t            stat_o,
  output logic                         done_o,
  output logic [hrs_pkg::StatusW-1:0]  status_o,
  output logic [hrs_pkg::NodeW-1:0]    node_out_o
);
  import hrs_pkg::*;

  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int OwnW  = (NODE_BITS < NodeW) ? NODE_BITS : NodeW;

  logic [HashW-1:0] pts_mem [MAX_POINTS];
  logic [OwnW-1:0]  own_mem [MAX_POINTS];

  logic [HashW-1:0] hash_q;
  logic [OwnW-1:0]  node_q;
  logic [CntW-1:0]  count_q, lo_q, hi_q, mid_q, idx_q;
  logic [CntW-1:0]  mid_d, idx_dn;
  logic [HashW-1:0] rd_pts_q;
  logic [OwnW-1:0]  rd_own_q;

  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [HashW-1:0] wr_pts;
  logic [OwnW-1:0]  wr_own;

  logic             done_q;
  status_e          status_q;
  logic [NodeW-1:0] node_out_q;

  assign mid_d  = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_dn = idx_q - CntW'(1);

  assign stat_o.count_zero  = (count_q == '0);
  assign stat_o.full        = (count_q == CntW'(MAX_POINTS));
  assign stat_o.lo_lt_hi    = (lo_q < hi_q);
  assign stat_o.pos_in_ring = (lo_q < count_q);
  assign stat_o.hit         = (rd_pts_q == hash_q);
  assign stat_o.shift_last  = (idx_dn == lo_q);

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hash_q <= hash_value_i;
      node_q <= node_in_i[OwnW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lo_q <= '0;
      hi_q <= count_q;
    end else if (cmd_i.srch_upd) begin
      if (rd_pts_q < hash_q) begin
        lo_q <= mid_q + CntW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid_d;
    end
    if (cmd_i.shift_init) begin
      idx_q <= count_q;
    end else if (cmd_i.shift_wr) begin
      idx_q <= idx_dn;
    end
  end

  // single read port, single write port
  assign rd_en = cmd_i.srch_rd | cmd_i.lkp_rd | cmd_i.pos_rd | cmd_i.shift_rd;

  always_comb begin
    priority if (cmd_i.srch_rd) begin
      rd_addr = mid_d[AddrW-1:0];
    end else if (cmd_i.lkp_rd) begin
      // wrap past the highest point to the lowest
      rd_addr = stat_o.pos_in_ring ? lo_q[AddrW-1:0] : '0;
    end else if (cmd_i.shift_rd) begin
      rd_addr = idx_dn[AddrW-1:0];
    end else begin
      rd_addr = lo_q[AddrW-1:0];
    end
  end

  assign wr_en   = cmd_i.wr_pos | cmd_i.shift_wr;
  assign wr_addr = cmd_i.shift_wr ? idx_q[AddrW-1:0] : lo_q[AddrW-1:0];
  assign wr_pts  = cmd_i.shift_wr ? rd_pts_q : hash_q;
  assign wr_own  = cmd_i.shift_wr ? rd_own_q : node_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pts_mem[wr_addr] <= wr_pts;
      own_mem[wr_addr] <= wr_own;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_pts_q <= pts_mem[rd_addr];
      rd_own_q <= own_mem[rd_addr];
    end
  end

  // result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= cmd_i.emit_status;
      node_out_q <= cmd_i.emit_node ? NodeW'(rd_own_q) : '0;
    end
  end

  assign done_o     = done_q;
  assign status_o   = status_q;
  assign node_out_o = node_out_q;

endmodule

// File: hw/rtl/hrs_ctrl.sv
// ----------------------------------------------------------------------------
// hrs_ctrl: request sequencer
// Walks lookups and inserts through search, then lookup read or tail shift
// and write, driving the datapath by commands and reading back its status.
// ----------------------------------------------------------------------------
module hrs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hrs_pkg::OpW-1:0]   opcode_i,
  output logic                      busy_o,
  output hrs_pkg::dp_cmd_t          cmd_o,
  input  hrs_pkg::dp_stat_t         stat_i
);
  import hrs_pkg::*;

  state_e state_q, state_d;
  op_e    op_q;
  op_e    op_in;

  assign op_in  = op_e'(opcode_i);
  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_NOP;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && start_i) begin
        op_q <= op_in;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (op_in)
            OP_INSERT: state_d = S_SRCH_RD;
            OP_LOOKUP: state_d = stat_i.count_zero ? S_IDLE : S_SRCH_RD;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (stat_i.lo_lt_hi) begin
          state_d = S_SRCH_CMP;
        end else begin
          state_d = (op_q == OP_LOOKUP) ? S_LKP_RD : S_INS_RD;
        end
      end
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_LKP_RD:   state_d = S_LKP_OUT;
      S_LKP_OUT:  state_d = S_IDLE;
      S_INS_RD: begin
        priority if (stat_i.pos_in_ring) begin
          state_d = S_INS_CHK;
        end else if (stat_i.full) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_CHK: begin
        priority if (stat_i.hit || stat_i.full) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = stat_i.shift_last ? S_INS_WR : S_SHIFT_RD;
      S_INS_WR:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          unique case (op_in)
            OP_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.emit  = 1'b1;
            end
            OP_LOOKUP: begin
              if (stat_i.count_zero) begin
                cmd_o.emit        = 1'b1;
                cmd_o.emit_status = ST_EMPTY;
              end
            end
            OP_NOP:    cmd_o.emit = 1'b1;
            default:   cmd_o.emit = 1'b0;
          endcase
        end
      end
      S_SRCH_RD:  cmd_o.srch_rd  = stat_i.lo_lt_hi;
      S_SRCH_CMP: cmd_o.srch_upd = 1'b1;
      S_LKP_RD:   cmd_o.lkp_rd   = 1'b1;
      S_LKP_OUT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_node = 1'b1;
      end
      S_INS_RD: begin
        priority if (stat_i.pos_in_ring) begin
          cmd_o.pos_rd = 1'b1;
        end else if (stat_i.full) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_FULL;
        end
      end
      S_INS_CHK: begin
        priority if (stat_i.hit) begin
          // existing point: replace the owner
          cmd_o.wr_pos = 1'b1;
          cmd_o.emit   = 1'b1;
        end else if (stat_i.full) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = ST_FULL;
        end else begin
          cmd_o.shift_init = 1'b1;
        end
      end
      S_SHIFT_RD: cmd_o.shift_rd = 1'b1;
      S_SHIFT_WR: cmd_o.shift_wr = 1'b1;
      S_INS_WR: begin
        cmd_o.wr_pos  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        cmd_o.emit    = 1'b1;
      end
      default: cmd_o.emit = 1'b0;
    endcase
  end

endmodule

// File: hw/rtl/hash_ring_successor_lookup.sv
// ----------------------------------------------------------------------------
// hash_ring_successor_lookup: consistent hash ring with successor search
// Sorted table of ring points tagged with node ids; clear, insert and
// lookup of the owner of the first point at or above a key hash.
//
//   channel   handshake            payload
//   request   start_i, busy_o      opcode_i, hash_value_i, node_in_i
//   result    done_o (one cycle)   status_o, node_out_o
//
// A request is taken when start_i is high and busy_o is low; its result
// shows in the cycle after the last step of its work, for one cycle.
// Clear, unused opcode and lookup on an empty ring: result the next cycle.
// Lookup: binary search, up to 13 steps for 4096 points, each step a memory
// read followed by a compare, then a read of the successor entry. Insert:
// the same search; an existing point gets the new owner, else entries move
// up to open the slot before the write; a full table drops the request.
// Reset empties the ring at once; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module hash_ring_successor_lookup #(
  parameter int MAX_POINTS = 4096,
  parameter int NODE_BITS  = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hrs_pkg::OpW-1:0]      opcode_i,
  input  logic [hrs_pkg::HashW-1:0]    hash_value_i,
  input  logic [hrs_pkg::NodeW-1:0]    node_in_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic [hrs_pkg::StatusW-1:0]  status_o,
  output logic [hrs_pkg::NodeW-1:0]    node_out_o
);
  import hrs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hrs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .stat_i   (stat)
  );

  hrs_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .NODE_BITS  (NODE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .hash_value_i (hash_value_i),
    .node_in_i    (node_in_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .done_o       (done_o),
    .status_o     (status_o),
    .node_out_o   (node_out_o)
  );

`ifndef SYNTHESIS
  // a result always lands with the sequencer back at rest
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // an accepted request either finishes at once or keeps the block busy
  a_accept_progress : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted request lost");

  // only a successful lookup carries a node id
  a_fail_no_node : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (node_out_o == '0))
    else $error("node id on failed request");

  // memory never written and read in the same step
  a_rw_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.wr_pos || cmd.shift_wr) |-> !(cmd.srch_rd || cmd.lkp_rd || cmd.shift_rd))
    else $error("read and write collide");
`endif

endmodule
